@@ src/vme_pkg.sv @@
// Shared types and constants of the semivariogram model evaluator.
// Used by vme_div, vme_ratio, vme_exp and variogram_model_eval; depends on nothing.
package vme_pkg;

   // internal ratio format: unsigned, QI fraction bits
   localparam int QI = 30;
   localparam int XW = 33;            // divider numerator (3*h or h), integer part
   localparam int RW = 31;            // range width
   localparam int QW = 35;            // quotient width, q < 32.0
   localparam int TW = 36;            // exp argument width, MSB set means t >= 32.0
   localparam int PW = 31;            // exp factor width, <= 1.0
   localparam int GFW = 30;           // reduced argument width, < ln2
   localparam int SFW = 32;           // spherical factor width
   localparam int TAYLOR_N = 7;

   localparam logic [PW-1:0] ONE_I = PW'(64'd1 << QI);
   localparam logic [GFW-1:0] LN2_I = 30'd744261118;
   localparam int RECIP_SH = 40;
   localparam int RECIP_W = 11;
   localparam logic [RECIP_W-1:0] LN2_RECIP = RECIP_W'((64'd1 << RECIP_SH) / LN2_I);
   localparam int KMW = TW - 1 + RECIP_W;
   localparam int KW = KMW - RECIP_SH;

   localparam int DIV_LAT = QW;
   localparam int RAT_LAT = 3;
   localparam int EXP_LAT = 3 * TAYLOR_N + 3;

   typedef enum logic [2:0] {
      MODEL_LINEAR      = 3'd0,
      MODEL_PARABOLIC   = 3'd1,
      MODEL_EXPONENTIAL = 3'd2,
      MODEL_SPHERICAL   = 3'd3,
      MODEL_GAUSSIAN    = 3'd4
   } model_type;

   typedef enum logic [2:0] {
      REG_MODEL     = 3'd0,
      REG_NUGGET    = 3'd1,
      REG_PSILL     = 3'd2,
      REG_RANGE     = 3'd3,
      REG_SLOPE     = 3'd4,
      REG_INTERCEPT = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [31:0] semivariance;
      logic               saturated;
   } rsp_word_type;

endpackage

@@ src/variogram_model_eval.sv @@
// Top level of the semivariogram model evaluator: registers, pipeline, output skid.
// Depends on vme_pkg, vme_div, vme_ratio and vme_exp.
//
//   channel | ports                                     | direction
//   req     | req_valid, req_ready, req_lag_dist        | in
//   rsp     | rsp_valid, rsp_ready, rsp_semivariance,   | out
//           | rsp_saturated                             |
//   csr     | csr_we, csr_index, csr_wdata              | in, write only
//
// One word per cycle while the skid is empty; a word passes the entry register, the
// 35-stage bit-per-stage divider, ratio unit, 24-stage exp unit and output registers.
// Synchronous active-high reset returns the configuration registers and valid flags to their defaults.
// A stalled rsp side fills a one-word skid; req_ready drops only while it is full.
module variogram_model_eval import vme_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [30:0]        req_lag_dist,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_semivariance,
   output logic               rsp_saturated,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
   localparam int VW = 62 - FRAC_BITS;       // (h*h) >> FRAC_BITS
   localparam int HW = VW - 31;
   localparam int PHW = 32 + HW + 1;
   localparam int SW = VW + 33;
   localparam int LW = 42;                   // clamped linear/parabolic term
   localparam int GW = 43;
   localparam int EXP_IDX = DIV_LAT + RAT_LAT + EXP_LAT;
   localparam int NST = EXP_IDX + 3;
   localparam int LIN_DLY = EXP_IDX - 2;
   localparam int FLAG_DLY = EXP_IDX;
   localparam int SPH_DLY = EXP_LAT;
   localparam logic signed [SW-1:0] BIG_W = {{(SW-41){1'b0}}, 1'b1, 40'b0};
   localparam logic signed [LW-1:0] BIG_L = {2'b01, 40'b0};
   localparam logic signed [GW-1:0] MAX_G = {{(GW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [GW-1:0] MIN_G = {{(GW-31){1'b1}}, 31'b0};

   // configuration registers
   logic [2:0]         model_ff;
   logic signed [31:0] nugget_ff, psill_ff, slope_ff, icpt_ff;
   logic [30:0]        range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff  <= MODEL_EXPONENTIAL;
         nugget_ff <= '0;
         psill_ff  <= ONE_Q;
         range_ff  <= ONE_Q[30:0];
         slope_ff  <= ONE_Q;
         icpt_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODEL:     model_ff  <= csr_wdata[2:0];
            REG_NUGGET:    nugget_ff <= csr_wdata;
            REG_PSILL:     psill_ff  <= csr_wdata;
            REG_RANGE:     range_ff  <= csr_wdata[30:0];
            REG_SLOPE:     slope_ff  <= csr_wdata;
            REG_INTERCEPT: icpt_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic             en;
   logic [NST-1:0]   vld_in, vld_ff;
   logic             rsp_vld_in, rsp_vld_ff;
   logic             skid_vld_in, skid_vld_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // entry stage: divider numerator and far-out flag
   logic [XW-1:0] h3;
   logic          rz;
   logic          is_exp;
   logic [30:0]   h_in, h_ff;
   logic [XW-1:0] x_in, x_ff;
   logic          full_in, full_ff;

   always_comb begin
      h3     = ({2'b0, req_lag_dist} << 1) + {2'b0, req_lag_dist};
      rz     = range_ff == '0;
      is_exp = model_ff == MODEL_EXPONENTIAL;
      h_in   = req_lag_dist;
      x_in   = is_exp ? h3 : {2'b0, req_lag_dist};
      case (model_ff)
         MODEL_EXPONENTIAL: full_in = rz || ({3'b0, h3} >= {range_ff, 5'b0});
         MODEL_SPHERICAL:   full_in = rz || (req_lag_dist >= range_ff);
         MODEL_GAUSSIAN:    full_in = rz || ({2'b0, req_lag_dist} >= {range_ff, 2'b0});
         default:           full_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff    <= h_in;
         x_ff    <= x_in;
         full_ff <= full_in;
      end
   end

   // ratio, powers and exp
   logic [QW-1:0]  q;
   logic [TW-1:0]  t;
   logic [SFW-1:0] fsph;
   logic [PW-1:0]  e;

   vme_div u_div (
      .clock     (clock),
      .en        (en),
      .x_val     (x_ff),
      .range_val (range_ff),
      .q_val     (q)
   );

   vme_ratio u_ratio (
      .clock     (clock),
      .en        (en),
      .gauss_sel (model_ff == MODEL_GAUSSIAN),
      .q_val     (q),
      .t_val     (t),
      .fsph_val  (fsph)
   );

   vme_exp u_exp (
      .clock (clock),
      .en    (en),
      .t_arg (t),
      .e_val (e)
   );

   // linear and parabolic terms
   logic signed [63:0]   lp_in, lp_ff, lp2_ff;
   logic [61:0]          hh_in, hh_ff;
   logic [VW-1:0]        vv;
   logic signed [63:0]   plo_in, plo_ff;
   logic signed [PHW-1:0] phi_in, phi_ff;
   logic signed [SW-1:0] psum, par_sh, lin_sh, term;
   logic signed [LW-1:0] s_in, s_ff;

   always_comb begin
      lp_in  = slope_ff * $signed({1'b0, h_ff});
      hh_in  = 62'(h_ff) * 62'(h_ff);
      vv     = hh_ff[61:FRAC_BITS];
      plo_in = slope_ff * $signed({1'b0, vv[30:0]});
      phi_in = slope_ff * $signed({1'b0, vv[VW-1:31]});
      psum   = ({{(SW-PHW){phi_ff[PHW-1]}}, phi_ff} <<< 31)
             + {{(SW-64){plo_ff[63]}}, plo_ff};
      par_sh = psum >>> FRAC_BITS;
      lin_sh = {{(SW-64){lp2_ff[63]}}, lp2_ff} >>> FRAC_BITS;
      term   = (model_ff == MODEL_PARABOLIC) ? par_sh : lin_sh;
      if (term > BIG_W) begin
         s_in = BIG_L;
      end else if (term < -BIG_W) begin
         s_in = -BIG_L;
      end else begin
         s_in = term[LW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lp_ff  <= lp_in;
         hh_ff  <= hh_in;
         lp2_ff <= lp_ff;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         s_ff   <= s_in;
      end
   end

   // alignment delay lines
   logic signed [LW-1:0] lin_d_ff  [LIN_DLY];
   logic                 full_d_ff [FLAG_DLY];
   logic [SFW-1:0]       sph_d_ff  [SPH_DLY];

   always_ff @(posedge clock) begin
      if (en) begin
         lin_d_ff[0]  <= s_ff;
         full_d_ff[0] <= full_ff;
         sph_d_ff[0]  <= fsph;
         for (int i = 1; i < LIN_DLY; i++) lin_d_ff[i] <= lin_d_ff[i-1];
         for (int i = 1; i < FLAG_DLY; i++) full_d_ff[i] <= full_d_ff[i-1];
         for (int i = 1; i < SPH_DLY; i++) sph_d_ff[i] <= sph_d_ff[i-1];
      end
   end

   // sill mix, model select and saturation
   logic [SFW-1:0]       f;
   logic signed [64:0]   mp_in, mp_ff;
   logic signed [64:0]   mp_sh;
   logic signed [GW-1:0] mix, lin, g;
   rsp_word_type         word_in, word_ff;

   always_comb begin
      if (full_d_ff[FLAG_DLY-1]) begin
         f = {1'b0, ONE_I};
      end else if (model_ff == MODEL_SPHERICAL) begin
         f = sph_d_ff[SPH_DLY-1];
      end else begin
         f = {1'b0, ONE_I - e};
      end
      mp_in = psill_ff * $signed({1'b0, f});
      mp_sh = mp_ff >>> QI;
      mix   = {{(GW-32){nugget_ff[31]}}, nugget_ff} + mp_sh[GW-1:0];
      lin   = {{(GW-LW){lin_d_ff[LIN_DLY-1][LW-1]}}, lin_d_ff[LIN_DLY-1]}
            + {{(GW-32){icpt_ff[31]}}, icpt_ff};
      case (model_ff)
         MODEL_LINEAR, MODEL_PARABOLIC:                   g = lin;
         MODEL_EXPONENTIAL, MODEL_SPHERICAL, MODEL_GAUSSIAN: g = mix;
         default:                                         g = '0;
      endcase
      if (g > MAX_G) begin
         word_in.semivariance = MAX_G[31:0];
         word_in.saturated    = 1'b1;
      end else if (g < MIN_G) begin
         word_in.semivariance = MIN_G[31:0];
         word_in.saturated    = 1'b1;
      end else begin
         word_in.semivariance = g[31:0];
         word_in.saturated    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mp_ff   <= mp_in;
         word_ff <= word_in;
      end
   end

   // output register and skid
   logic         push, pop;
   rsp_word_type rsp_word_in, rsp_word_ff;
   rsp_word_type skid_word_in, skid_word_ff;

   always_comb begin
      push         = en && vld_ff[NST-1];
      pop          = rsp_vld_ff && rsp_ready;
      rsp_vld_in   = rsp_vld_ff;
      skid_vld_in  = skid_vld_ff;
      rsp_word_in  = rsp_word_ff;
      skid_word_in = skid_word_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            rsp_word_in = skid_word_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_vld_ff || pop) begin
            rsp_word_in = word_ff;
            rsp_vld_in  = 1'b1;
         end else begin
            skid_word_in = word_ff;
            skid_vld_in  = 1'b1;
         end
      end else if (pop) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_semivariance = rsp_word_ff.semivariance;
   assign rsp_saturated    = rsp_word_ff.saturated;

`ifndef SYNTHESIS
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_vld_ff)
      else $error("skid holds a word while the output register is empty");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_semivariance == 32'sh7fffffff || rsp_semivariance == -32'sh80000000))
      else $error("saturated word is not at a limit");

   a_unused_model_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (model_ff > MODEL_GAUSSIAN) |->
         (rsp_semivariance == '0 && !rsp_saturated))
      else $error("unused model code gave a nonzero word");

   a_stall_holds_skid: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_ready |=> skid_vld_ff && $stable(skid_word_ff))
      else $error("skid word changed while the output is stalled");
`endif

endmodule

@@ src/vme_div.sv @@
// Pipelined restoring divider: q = (x << QI) / range, one quotient bit per stage.
// Depends on vme_pkg. DIV_LAT pipeline stages, advances when en is high.
module vme_div import vme_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [XW-1:0] x_val,
   input  logic [RW-1:0] range_val,
   output logic [QW-1:0] q_val
);

   localparam int SB = QW - QI;   // numerator bits still to shift in

   logic [RW:0]   rem_c [QW+1];
   logic [SB-1:0] nb_c  [QW+1];
   logic [QW-1:0] quo_c [QW+1];

   assign rem_c[0] = (RW+1)'(x_val >> SB);
   assign nb_c[0]  = x_val[SB-1:0];
   assign quo_c[0] = '0;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [RW:0]   tr;
      logic          ge;
      logic [RW:0]   rem_in, rem_ff;
      logic [SB-1:0] nb_in, nb_ff;
      logic [QW-1:0] quo_in, quo_ff;

      always_comb begin
         tr     = {rem_c[s][RW-1:0], nb_c[s][SB-1]};
         ge     = tr >= {1'b0, range_val};
         rem_in = ge ? tr - {1'b0, range_val} : tr;
         nb_in  = nb_c[s] << 1;
         quo_in = {quo_c[s][QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            nb_ff  <= nb_in;
            quo_ff <= quo_in;
         end
      end

      assign rem_c[s+1] = rem_ff;
      assign nb_c[s+1]  = nb_ff;
      assign quo_c[s+1] = quo_ff;
   end

   assign q_val = quo_c[QW];

endmodule

@@ src/vme_ratio.sv @@
// Powers of the distance ratio: exp argument (q or 3*q^2) and spherical factor.
// Depends on vme_pkg. RAT_LAT pipeline stages, advances when en is high.
module vme_ratio import vme_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  logic           gauss_sel,
   input  logic [QW-1:0]  q_val,
   output logic [TW-1:0]  t_val,
   output logic [SFW-1:0] fsph_val
);

   logic [63:0]    sq_in, sq_ff;
   logic [QW-1:0]  qa_in, qa_ff;
   logic [33:0]    q2;
   logic [63:0]    cube_in, cube_ff;
   logic [TW-1:0]  tg_in, tg_ff;
   logic [QW-1:0]  qb_ff;
   logic [33:0]    q3;
   logic [33:0]    three_q;
   logic [33:0]    diff;
   logic [TW-1:0]  t_in, t_ff;
   logic [SFW-1:0] f_in, f_ff;

   always_comb begin
      sq_in   = 64'(q_val[31:0]) * 64'(q_val[31:0]);
      qa_in   = q_val;
      q2      = sq_ff[63:QI];
      cube_in = 64'(q2[31:0]) * 64'(qa_ff[31:0]);
      tg_in   = ({2'b0, q2} << 1) + {2'b0, q2};
      q3      = cube_ff[63:QI];
      three_q = ({2'b0, qb_ff[31:0]} << 1) + {2'b0, qb_ff[31:0]};
      diff    = three_q - q3;
      f_in    = diff[SFW:1];
      t_in    = gauss_sel ? tg_ff : {1'b0, qb_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         qa_ff   <= qa_in;
         cube_ff <= cube_in;
         tg_ff   <= tg_in;
         qb_ff   <= qa_ff;
         t_ff    <= t_in;
         f_ff    <= f_in;
      end
   end

   assign t_val    = t_ff;
   assign fsph_val = f_ff;

endmodule

@@ src/vme_exp.sv @@
// exp(-t) in QI fixed point: range reduction by ln2, degree-7 Taylor series, shift.
// Depends on vme_pkg. EXP_LAT pipeline stages, advances when en is high.
module vme_exp import vme_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [TW-1:0] t_arg,
   output logic [PW-1:0] e_val
);

   typedef struct packed {
      logic [GFW-1:0] g;
      logic [KW-1:0]  k;
      logic           zero;
   } side_type;

   // range reduction
   logic [KMW-1:0]  km_in, km_ff;
   logic [TW-2:0]   t0_ff;
   logic            z0_ff;
   logic [KW-1:0]   k_est;
   logic [TW-2:0]   kl;
   logic [TW-2:0]   gr;
   logic            gr_ge;
   side_type        side_in, side_ff;

   always_comb begin
      km_in        = KMW'(t_arg[TW-2:0]) * KMW'(LN2_RECIP);
      k_est        = km_ff[KMW-1:RECIP_SH];
      kl           = (TW-1)'(k_est) * (TW-1)'(LN2_I);
      gr           = t0_ff - kl;
      gr_ge        = gr >= (TW-1)'(LN2_I);
      side_in.g    = gr_ge ? GFW'(gr - (TW-1)'(LN2_I)) : GFW'(gr);
      side_in.k    = k_est + KW'(gr_ge);
      side_in.zero = z0_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         km_ff   <= km_in;
         t0_ff   <= t_arg[TW-2:0];
         z0_ff   <= t_arg[TW-1];
         side_ff <= side_in;
      end
   end

   // nested Taylor steps: p = 1 - ((g*p) >> QI) / n, n = 7 down to 1
   logic [PW-1:0] p_c [TAYLOR_N+1];
   side_type      s_c [TAYLOR_N+1];

   assign p_c[0] = ONE_I;
   assign s_c[0] = side_ff;

   for (genvar j = 0; j < TAYLOR_N; j++) begin : g_step
      localparam int unsigned N = TAYLOR_N - j;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
      localparam logic [GFW-1:0] NV = GFW'(N);

      logic [GFW+PW-1:0] gp_in, gp_ff;
      side_type          sa_ff, sb_ff, sc_ff;
      logic [GFW-1:0]    x_in, x_ff;
      logic [62:0]       m_in, m_ff;
      logic [GFW-1:0]    est, rem, quo;
      logic [PW-1:0]     p_in, p_ff;

      always_comb begin
         gp_in = (GFW+PW)'(s_c[j].g) * (GFW+PW)'(p_c[j]);
         x_in  = gp_ff[2*QI-1:QI];
         m_in  = 63'(x_in) * 63'(RECIP);
         est   = m_ff[61:32];
         rem   = x_ff - est * NV;
         quo   = (rem >= NV) ? est + GFW'(1) : est;
         p_in  = ONE_I - {1'b0, quo};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            gp_ff <= gp_in;
            sa_ff <= s_c[j];
            x_ff  <= x_in;
            m_ff  <= m_in;
            sb_ff <= sa_ff;
            p_ff  <= p_in;
            sc_ff <= sb_ff;
         end
      end

      assign p_c[j+1] = p_ff;
      assign s_c[j+1] = sc_ff;
   end

   logic [PW-1:0] e_in, e_ff;

   always_comb begin
      e_in = s_c[TAYLOR_N].zero ? '0 : p_c[TAYLOR_N] >> s_c[TAYLOR_N].k;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
      end
   end

   assign e_val = e_ff;

endmodule
